/* rtl/core/tgpp_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none

package tgpp_pkg;

    // one received byte of the datagram
    typedef struct packed {
        logic [7:0] rx_byte;
        logic       packet_start;
    } tgpp_in_t;

    // one result beat: group record or end-of-packet status
    typedef struct packed {
        logic        result_kind;
        logic [2:0]  group_code;
        logic [31:0] value_a;
        logic [31:0] value_b;
        logic [31:0] value_c;
        logic        packet_ok;
    } tgpp_out_t;

    // parser phases
    typedef enum logic [2:0] {
        PH_IDLE,
        PH_HDR_N,
        PH_MASK_L,
        PH_MASK_H,
        PH_ID,
        PH_BODY,
        PH_TERM
    } tgpp_phase_t;

    // handshake between the input stage and the parse step
    typedef struct packed {
        logic valid;
        logic fire;
    } tgpp_step_t;

    // framing characters
    localparam logic [7:0] CH_START = 8'h50;  // 'P'
    localparam logic [7:0] CH_HDR_N = 8'h4E;  // 'N'
    localparam logic [7:0] CH_TERM  = 8'h21;  // '!'

    // group ids
    localparam logic [7:0] ID_ACCEL    = 8'h32;  // '2'
    localparam logic [7:0] ID_RATES    = 8'h33;  // '3'
    localparam logic [7:0] ID_ATTITUDE = 8'h34;  // '4'
    localparam logic [7:0] ID_AIRFLOW  = 8'h35;  // '5'
    localparam logic [7:0] ID_POSITION = 8'h37;  // '7'

    // group codes on the result
    localparam logic [2:0] GRP_ACCEL    = 3'd0;
    localparam logic [2:0] GRP_RATES    = 3'd1;
    localparam logic [2:0] GRP_ATTITUDE = 3'd2;
    localparam logic [2:0] GRP_AIRFLOW  = 3'd3;
    localparam logic [2:0] GRP_POSITION = 3'd4;

    // result kinds
    localparam logic KIND_RECORD = 1'b0;
    localparam logic KIND_STATUS = 1'b1;

    // group body layout: three kept words, then word four and checksum
    localparam int         NUM_WORDS      = 3;
    localparam logic [4:0] BODY_KEEP_END  = 5'd12;
    localparam logic [4:0] BODY_LAST      = 5'd16;

endpackage

`default_nettype wire

/* rtl/core/tgpp_in_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgpp_in_stage (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              byte_valid,
    output logic                   byte_stall,
    input  wire tgpp_pkg::tgpp_in_t byte_data,
    input  wire logic              hold,
    output tgpp_pkg::tgpp_step_t   step,
    output tgpp_pkg::tgpp_in_t     item
);
    import tgpp_pkg::*;

    logic     item_valid_reg;
    logic     item_valid_next;
    tgpp_in_t item_reg;

    // stall only while a byte is held and the parse step cannot advance
    assign byte_stall = item_valid_reg && hold;

    // next valid: new beat when open, keep held beat otherwise
    always_comb
    begin
        if (byte_stall)
        begin
            item_valid_next = item_valid_reg;
        end
        else
        begin
            item_valid_next = byte_valid;
        end
    end

    // control register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid_reg <= 1'b0;
        end
        else
        begin
            item_valid_reg <= item_valid_next;
        end
    end

    // payload register
    always_ff @(posedge clk)
    begin
        if (!byte_stall && byte_valid)
        begin
            item_reg <= byte_data;
        end
    end

    assign step.valid = item_valid_reg;
    assign step.fire  = item_valid_reg && !hold;
    assign item       = item_reg;

endmodule

`default_nettype wire

/* rtl/core/tgpp_parse.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgpp_parse (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tgpp_pkg::tgpp_step_t step,
    input  wire tgpp_pkg::tgpp_in_t   item,
    output logic                     rec_valid,
    output tgpp_pkg::tgpp_out_t      rec
);
    import tgpp_pkg::*;

    tgpp_phase_t phase_reg;
    tgpp_phase_t phase_next;
    logic [7:0]  mask_reg;
    logic [7:0]  mask_next;
    logic [7:0]  mask_retired;
    logic [4:0]  count_reg;
    logic [4:0]  count_next;
    logic [2:0]  group_reg;
    logic [2:0]  group_next;
    logic [31:0] word_buf_reg [NUM_WORDS];
    logic        id_known;
    logic [2:0]  id_code;
    logic        word_we;
    logic [1:0]  word_sel;
    logic [7:0]  rx;

    assign rx           = item.rx_byte;
    assign mask_retired = mask_reg & (mask_reg - 8'd1);

    // group id decode
    always_comb
    begin
        id_known = 1'b1;
        id_code  = GRP_ACCEL;
        unique case (rx)
            ID_ACCEL:    id_code = GRP_ACCEL;
            ID_RATES:    id_code = GRP_RATES;
            ID_ATTITUDE: id_code = GRP_ATTITUDE;
            ID_AIRFLOW:  id_code = GRP_AIRFLOW;
            ID_POSITION: id_code = GRP_POSITION;
            default:     id_known = 1'b0;
        endcase
    end

    // next phase
    always_comb
    begin
        phase_next = phase_reg;
        if (step.fire)
        begin
            if (item.packet_start)
            begin
                phase_next = (rx == CH_START) ? PH_HDR_N : PH_IDLE;
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:   phase_next = PH_IDLE;
                    PH_HDR_N:  phase_next = (rx == CH_HDR_N) ? PH_MASK_L : PH_IDLE;
                    PH_MASK_L: phase_next = PH_MASK_H;
                    PH_MASK_H: phase_next = (mask_reg == 8'd0) ? PH_TERM : PH_ID;
                    PH_ID:     phase_next = id_known ? PH_BODY : PH_IDLE;
                    PH_BODY:
                    begin
                        if (count_reg >= BODY_LAST)
                        begin
                            phase_next = (mask_retired == 8'd0) ? PH_TERM : PH_ID;
                        end
                    end
                    PH_TERM:   phase_next = PH_IDLE;
                    default:   phase_next = PH_IDLE;
                endcase
            end
        end
    end

    // outputs and datapath state
    always_comb
    begin
        mask_next  = mask_reg;
        count_next = count_reg;
        group_next = group_reg;
        word_we    = 1'b0;
        word_sel   = count_reg[3:2];
        rec_valid  = 1'b0;
        rec        = '0;
        if (step.fire)
        begin
            if (item.packet_start)
            begin
                if (rx != CH_START)
                begin
                    rec_valid        = 1'b1;
                    rec.result_kind  = KIND_STATUS;
                end
            end
            else
            begin
                unique case (phase_reg)
                    PH_IDLE:
                    begin
                    end
                    PH_HDR_N:
                    begin
                        if (rx != CH_HDR_N)
                        begin
                            rec_valid       = 1'b1;
                            rec.result_kind = KIND_STATUS;
                        end
                    end
                    PH_MASK_L:
                    begin
                        mask_next = rx;
                    end
                    PH_MASK_H:
                    begin
                    end
                    PH_ID:
                    begin
                        if (id_known)
                        begin
                            group_next = id_code;
                            count_next = 5'd0;
                        end
                        else
                        begin
                            rec_valid       = 1'b1;
                            rec.result_kind = KIND_STATUS;
                        end
                    end
                    PH_BODY:
                    begin
                        word_we = (count_reg < BODY_KEEP_END);
                        if (count_reg >= BODY_LAST)
                        begin
                            rec_valid       = 1'b1;
                            rec.result_kind = KIND_RECORD;
                            rec.group_code  = group_reg;
                            rec.value_a     = word_buf_reg[0];
                            rec.value_b     = word_buf_reg[1];
                            rec.value_c     = word_buf_reg[2];
                            mask_next       = mask_retired;
                            count_next      = 5'd0;
                        end
                        else
                        begin
                            count_next = count_reg + 5'd1;
                        end
                    end
                    PH_TERM:
                    begin
                        rec_valid       = 1'b1;
                        rec.result_kind = KIND_STATUS;
                        rec.packet_ok   = (rx == CH_TERM);
                    end
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_IDLE;
            mask_reg  <= 8'd0;
            count_reg <= 5'd0;
            group_reg <= GRP_ACCEL;
        end
        else
        begin
            phase_reg <= phase_next;
            mask_reg  <= mask_next;
            count_reg <= count_next;
            group_reg <= group_next;
        end
    end

    // little-endian word assembly, newest byte enters at the top
    for (genvar gi = 0; gi < NUM_WORDS; gi++)
    begin : g_word
        always_ff @(posedge clk)
        begin
            if (word_we && (word_sel == 2'(gi)))
            begin
                word_buf_reg[gi] <= {rx, word_buf_reg[gi][31:8]};
            end
        end
    end

    // body position never runs past the checksum byte
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        (phase_reg == PH_BODY) |-> (count_reg <= BODY_LAST))
        else $error("group byte count past checksum");

    // terminator phase always closes the packet with a status
    a_term_status: assert property (@(posedge clk) disable iff (!rst_n)
        (step.fire && !item.packet_start && (phase_reg == PH_TERM))
            |-> (rec_valid && (rec.result_kind == KIND_STATUS)))
        else $error("terminator byte without status");

    // after a status the parser sits idle unless a start byte follows
    a_status_idle: assert property (@(posedge clk) disable iff (!rst_n)
        (rec_valid && (rec.result_kind == KIND_STATUS)) |=> (phase_reg == PH_IDLE))
        else $error("parser not idle after status");

endmodule

`default_nettype wire

/* rtl/core/tgpp_out_stage.sv */
`timescale 1ns / 1ps
`default_nettype none

module tgpp_out_stage (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire tgpp_pkg::tgpp_step_t step,
    input  wire logic                rec_valid,
    input  wire tgpp_pkg::tgpp_out_t  rec,
    output logic                     hold,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output tgpp_pkg::tgpp_out_t      res_data
);
    import tgpp_pkg::*;

    logic      res_valid_reg;
    logic      res_valid_next;
    tgpp_out_t res_data_reg;

    // a waiting result blocks the parse step
    assign hold = res_valid_reg && res_stall;

    // next valid: load a new result, keep a stalled one, else drain
    always_comb
    begin
        if (hold)
        begin
            res_valid_next = 1'b1;
        end
        else
        begin
            res_valid_next = step.fire && rec_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_valid_reg <= 1'b0;
        end
        else
        begin
            res_valid_reg <= res_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (step.fire && rec_valid)
        begin
            res_data_reg <= rec;
        end
    end

    assign res_valid = res_valid_reg;
    assign res_data  = res_data_reg;

    // a taken result with nothing new behind it leaves the register empty
    a_drain: assert property (@(posedge clk) disable iff (!rst_n)
        (res_valid_reg && !res_stall && !step.valid) |=> !res_valid_reg)
        else $error("result repeated after it was taken");

endmodule

`default_nettype wire

/* rtl/core/telemetry_group_packet_parser_core.sv */
// a completing byte sits in the input register, then its result beat in the result register
// one byte per cycle unless stalled, one parse step per byte between input and result regs
// a result waiting under stall holds the parse step; one more byte is still buffered
// reset: asynchronous active low, clears valid flags and parser state to idle
// the assembled group words are not reset and are always written before use
`timescale 1ns / 1ps
`default_nettype none

module telemetry_group_packet_parser_core (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                byte_valid,
    output logic                     byte_stall,
    input  wire tgpp_pkg::tgpp_in_t   byte_data,
    output logic                     res_valid,
    input  wire logic                res_stall,
    output tgpp_pkg::tgpp_out_t      res_data
);
    import tgpp_pkg::*;

    tgpp_step_t step;
    tgpp_in_t   item;
    tgpp_out_t  rec;
    logic       rec_valid;
    logic       hold;

    // input register
    tgpp_in_stage u_in (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .hold       (hold),
        .step       (step),
        .item       (item)
    );

    // parser state and one-byte step
    tgpp_parse u_parse (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .item      (item),
        .rec_valid (rec_valid),
        .rec       (rec)
    );

    // result register
    tgpp_out_stage u_out (
        .clk       (clk),
        .rst_n     (rst_n),
        .step      (step),
        .rec_valid (rec_valid),
        .rec       (rec),
        .hold      (hold),
        .res_valid (res_valid),
        .res_stall (res_stall),
        .res_data  (res_data)
    );

    // input side only stalls behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        byte_stall |-> (res_valid && res_stall))
        else $error("input stalled with result side open");

endmodule

`default_nettype wire

/* dv/telemetry_group_packet_parser_core_tb.sv */
`timescale 1ns / 1ps

module telemetry_group_packet_parser_core_tb;

    import tgpp_pkg::*;

    // ways a generated packet can be broken
    typedef enum
    {
        FLT_NONE,
        FLT_BAD_START,
        FLT_BAD_N,
        FLT_BAD_ID,
        FLT_BAD_TERM,
        FLT_CUT
    } pkt_fault_t;

    // one byte waiting to be sent, with its trailing gap
    typedef struct
    {
        tgpp_in_t    beat;
        int unsigned gap;
        bit          drain;
    } byte_item_t;

    logic      clk;
    logic      rst_n;
    logic      byte_valid;
    logic      byte_stall;
    tgpp_in_t  byte_data;
    logic      res_valid;
    logic      res_stall;
    tgpp_out_t res_data;

    telemetry_group_packet_parser_core u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .byte_valid (byte_valid),
        .byte_stall (byte_stall),
        .byte_data  (byte_data),
        .res_valid  (res_valid),
        .res_stall  (res_stall),
        .res_data   (res_data)
    );

    // datagram bytes still to send and results still owed
    byte_item_t  byte_q[$];
    tgpp_out_t   exp_results[$];
    int          queued_total;
    int          stim_count;
    int          sent_cnt;
    int          predicted_cnt;
    int          checked_cnt;
    int          mismatch_cnt;
    bit          fast_send;
    bit          fast_recv;
    bit          drain_next;
    int unsigned gap_left;
    int unsigned stall_left;

    // scratch for the clocked blocks
    tgpp_out_t   predicted_beat;
    tgpp_out_t   want_beat;
    bit          made_result;
    int          outstanding;
    byte_item_t  next_item;
    int unsigned stall_draw;

    // parser state as predicted
    tgpp_phase_t pred_phase;
    logic [7:0]  pred_mask;
    logic [4:0]  pred_count;
    logic [2:0]  pred_code;
    logic [31:0] pred_words[3];

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    initial
    begin
        #5_000_000;
        $display("FAILURE");
        $finish;
    end

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("mismatch at %0t: %s got %h want %h", $realtime, what, got, want);
        mismatch_cnt++;
    endtask

    // status beat closes the packet and drops the parser to idle
    function automatic tgpp_out_t end_packet(input logic ok);
        end_packet = '0;
        end_packet.result_kind = KIND_STATUS;
        end_packet.packet_ok = ok;
        pred_phase = PH_IDLE;
    endfunction

    // one byte through the parser; returns 1 when a beat is due
    function automatic bit predict_parse(input tgpp_in_t beat, output tgpp_out_t rec);
        logic [7:0] b;
        b = beat.rx_byte;
        rec = '0;
        if (beat.packet_start)
        begin
            if (b != CH_START)
            begin
                rec = end_packet(1'b0);
                return 1'b1;
            end
            pred_phase = PH_HDR_N;
            return 1'b0;
        end
        case (pred_phase)
            PH_HDR_N:
            begin
                if (b != CH_HDR_N)
                begin
                    rec = end_packet(1'b0);
                    return 1'b1;
                end
                pred_phase = PH_MASK_L;
            end
            PH_MASK_L:
            begin
                pred_mask = b;
                pred_phase = PH_MASK_H;
            end
            // high mask byte carries nothing
            PH_MASK_H: pred_phase = (pred_mask == 8'h00) ? PH_TERM : PH_ID;
            PH_ID:
            begin
                case (b)
                    ID_ACCEL:    pred_code = GRP_ACCEL;
                    ID_RATES:    pred_code = GRP_RATES;
                    ID_ATTITUDE: pred_code = GRP_ATTITUDE;
                    ID_AIRFLOW:  pred_code = GRP_AIRFLOW;
                    ID_POSITION: pred_code = GRP_POSITION;
                    default:
                    begin
                        rec = end_packet(1'b0);
                        return 1'b1;
                    end
                endcase
                pred_count = '0;
                pred_phase = PH_BODY;
            end
            PH_BODY:
            begin
                // little-endian words shift in from the top
                if (pred_count < BODY_KEEP_END)
                    pred_words[pred_count[3:2]] = {b, pred_words[pred_count[3:2]][31:8]};
                if (pred_count >= BODY_LAST)
                begin
                    rec.result_kind = KIND_RECORD;
                    rec.group_code = pred_code;
                    rec.value_a = pred_words[0];
                    rec.value_b = pred_words[1];
                    rec.value_c = pred_words[2];
                    rec.packet_ok = 1'b0;
                    pred_mask = pred_mask & (pred_mask - 8'h01);
                    pred_count = '0;
                    pred_phase = (pred_mask == 8'h00) ? PH_TERM : PH_ID;
                    return 1'b1;
                end
                pred_count = pred_count + 5'd1;
            end
            PH_TERM:
            begin
                rec = end_packet(b == CH_TERM);
                return 1'b1;
            end
            default: pred_phase = PH_IDLE;
        endcase
        return 1'b0;
    endfunction

    task automatic check_result(input tgpp_out_t got, input tgpp_out_t want);
        if (got.result_kind !== want.result_kind)
            report_mismatch("result_kind", got.result_kind, want.result_kind);
        if (got.group_code !== want.group_code)
            report_mismatch("group_code", got.group_code, want.group_code);
        if (got.value_a !== want.value_a)
            report_mismatch("value_a", got.value_a, want.value_a);
        if (got.value_b !== want.value_b)
            report_mismatch("value_b", got.value_b, want.value_b);
        if (got.value_c !== want.value_c)
            report_mismatch("value_c", got.value_c, want.value_c);
        if (got.packet_ok !== want.packet_ok)
            report_mismatch("packet_ok", got.packet_ok, want.packet_ok);
    endtask

    task automatic queue_byte(input logic [7:0] b, input logic s, input bit counted);
        byte_item_t item;
        item.beat.rx_byte = b;
        item.beat.packet_start = s;
        item.gap = fast_send ? 0 : $urandom_range(0, 10);
        item.drain = drain_next;
        drain_next = 1'b0;
        byte_q.push_back(item);
        queued_total++;
        if (counted)
            stim_count++;
    endtask

    // header, mask, groups and terminator with random content
    task automatic queue_packet(input pkt_fault_t fault);
        logic [7:0] mask;
        logic [7:0] b;
        logic [7:0] tail[$];
        int         n_groups;
        int         bad_at;
        int         fill_mode;
        int         keep;
        case ($urandom_range(0, 9))
            0:          mask = 8'h00;
            1, 2, 3, 4: mask = 8'h01 << $urandom_range(0, 7);
            5, 6, 7:    mask = (8'h01 << $urandom_range(0, 7)) | (8'h01 << $urandom_range(0, 7));
            8:          mask = $urandom;
            default:    mask = 8'hFF;
        endcase
        if (fault == FLT_BAD_ID && mask == 8'h00)
            mask = 8'h01 << $urandom_range(0, 7);
        n_groups = $countones(mask);
        bad_at = (fault == FLT_BAD_ID) ? $urandom_range(0, n_groups - 1) : -1;

        // header
        if (fault == FLT_BAD_START)
        begin
            do b = $urandom; while (b == CH_START);
            queue_byte(b, 1'b1, 1'b1);
            return;
        end
        queue_byte(CH_START, 1'b1, 1'b1);
        if (fault == FLT_BAD_N)
        begin
            do b = $urandom; while (b == CH_HDR_N);
            queue_byte(b, 1'b0, 1'b1);
            return;
        end
        queue_byte(CH_HDR_N, 1'b0, 1'b1);
        queue_byte(mask, 1'b0, 1'b1);
        b = $urandom;
        queue_byte(b, 1'b0, 1'b1);

        // groups
        for (int g = 0; g < n_groups; g++)
        begin
            if (g == bad_at)
            begin
                do b = $urandom;
                while (b == ID_ACCEL || b == ID_RATES || b == ID_ATTITUDE ||
                       b == ID_AIRFLOW || b == ID_POSITION);
                tail.push_back(b);
                break;
            end
            case ($urandom_range(0, 4))
                0:       b = ID_ACCEL;
                1:       b = ID_RATES;
                2:       b = ID_ATTITUDE;
                3:       b = ID_AIRFLOW;
                default: b = ID_POSITION;
            endcase
            tail.push_back(b);
            fill_mode = $urandom_range(0, 7);
            repeat (17)
            begin
                b = $urandom;
                if (fill_mode == 0)
                    b = 8'h00;
                else if (fill_mode == 1)
                    b = 8'hFF;
                tail.push_back(b);
            end
        end

        // terminator
        if (bad_at < 0)
        begin
            if (fault == FLT_BAD_TERM)
            begin
                do b = $urandom; while (b == CH_TERM);
            end
            else
                b = CH_TERM;
            tail.push_back(b);
        end

        keep = (fault == FLT_CUT) ? $urandom_range(0, tail.size() - 1) : tail.size();
        for (int i = 0; i < keep; i++)
            queue_byte(tail[i], 1'b0, 1'b1);
    endtask

    // byte driver with per-beat gaps and optional drain before a beat
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            byte_valid <= 1'b0;
            byte_data <= '0;
            gap_left <= 0;
            sent_cnt <= 0;
            predicted_cnt <= 0;
        end
        else
        begin
            made_result = 1'b0;
            if (byte_valid && !byte_stall)
            begin
                made_result = predict_parse(byte_data, predicted_beat);
                if (made_result)
                    exp_results.push_back(predicted_beat);
                sent_cnt <= sent_cnt + 1;
                predicted_cnt <= predicted_cnt + (made_result ? 1 : 0);
            end
            outstanding = predicted_cnt + (made_result ? 1 : 0) - checked_cnt;
            if (!byte_valid || !byte_stall)
            begin
                if (gap_left != 0)
                begin
                    byte_valid <= 1'b0;
                    gap_left <= gap_left - 1;
                end
                else if (byte_q.size() != 0 && !(byte_q[0].drain && outstanding > 0))
                begin
                    next_item = byte_q.pop_front();
                    byte_data <= next_item.beat;
                    byte_valid <= 1'b1;
                    gap_left <= next_item.gap;
                end
                else
                    byte_valid <= 1'b0;
            end
        end
    end

    // result monitor with per-beat stalls
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_stall <= 1'b0;
            stall_left <= 0;
            checked_cnt <= 0;
            fast_recv <= 1'b0;
        end
        else if (res_valid && !res_stall)
        begin
            if (exp_results.size() == 0)
                report_mismatch("result beat with nothing expected", res_data.value_a, 0);
            else
            begin
                want_beat = exp_results.pop_front();
                check_result(res_data, want_beat);
            end
            checked_cnt <= checked_cnt + 1;
            stall_draw = fast_recv ? 0 : $urandom_range(0, 10);
            if ($urandom_range(0, 7) == 0)
                fast_recv <= !fast_recv;
            stall_left <= stall_draw;
            res_stall <= (stall_draw != 0);
        end
        else if (res_valid && stall_left != 0)
        begin
            stall_left <= stall_left - 1;
            res_stall <= (stall_left > 1);
        end
    end

    // stimulus, reset and end of run
    initial
    begin
        int sel;
        logic [7:0] noise;
        rst_n = 1'b0;
        byte_valid = 1'b0;
        byte_data = '0;
        res_stall = 1'b0;
        queued_total = 0;
        stim_count = 0;
        mismatch_cnt = 0;
        fast_send = 1'b0;
        drain_next = 1'b0;
        pred_phase = PH_IDLE;
        pred_mask = '0;
        pred_count = '0;
        pred_code = '0;
        pred_words[0] = '0;
        pred_words[1] = '0;
        pred_words[2] = '0;

        // bytes while idle are dropped
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        // start byte that is not the sync char
        queue_byte(8'hFF, 1'b1, 1'b1);
        // bad second header byte
        queue_byte(CH_START, 1'b1, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        // empty mask, high mask byte all ones, good terminator
        queue_byte(CH_START, 1'b1, 1'b1);
        queue_byte(CH_HDR_N, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'hFF, 1'b0, 1'b1);
        queue_byte(CH_TERM, 1'b0, 1'b1);
        // empty mask, wrong terminator
        queue_byte(CH_START, 1'b1, 1'b1);
        queue_byte(CH_HDR_N, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        // restart in mid-packet, then unknown group id
        queue_byte(CH_START, 1'b1, 1'b1);
        queue_byte(CH_HDR_N, 1'b0, 1'b1);
        queue_byte(8'h80, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(CH_START, 1'b1, 1'b1);
        queue_byte(CH_HDR_N, 1'b0, 1'b1);
        queue_byte(8'h01, 1'b0, 1'b1);
        queue_byte(8'h00, 1'b0, 1'b1);
        queue_byte(8'h36, 1'b0, 1'b1);

        // random packets, mostly well formed; first one waits for a full drain
        drain_next = 1'b1;
        while (stim_count < 1450)
        begin
            fast_send = ($urandom_range(0, 3) == 0);
            if ($urandom_range(0, 9) == 0)
                drain_next = 1'b1;
            sel = $urandom_range(0, 19);
            if (sel < 14)
                queue_packet(FLT_NONE);
            else if (sel == 14)
                queue_packet(FLT_BAD_START);
            else if (sel == 15)
                queue_packet(FLT_BAD_N);
            else if (sel == 16)
                queue_packet(FLT_BAD_ID);
            else if (sel == 17)
                queue_packet(FLT_BAD_TERM);
            else if (sel == 18)
                queue_packet(FLT_CUT);
            else
            begin
                repeat ($urandom_range(1, 6))
                begin
                    noise = $urandom;
                    queue_byte(noise, ($urandom_range(0, 7) == 0), 1'b0);
                end
            end
        end

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        while (sent_cnt < queued_total || predicted_cnt > checked_cnt)
            @(posedge clk);
        repeat (30) @(posedge clk);

        if (exp_results.size() != 0)
            report_mismatch("expected beats never arrived", exp_results.size(), 0);
        if (mismatch_cnt == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule
